// ===== src/rup_pkg.sv =====
// Shared constants, types and arithmetic helpers for the radial undistortion block.
`timescale 1ns / 1ps

package rup_pkg;

   // Fixed point format and datapath widths
   localparam int FRAC_BITS = 24;
   localparam int XY_W      = 32;
   localparam int ACC_W     = 64;
   localparam int R_W       = ACC_W - FRAC_BITS;
   localparam int B1_W      = R_W - 32;
   localparam int PROD_W    = ACC_W + R_W;
   localparam int NUM_W     = XY_W + FRAC_BITS;
   localparam int QUO_W     = XY_W + 1;
   localparam int DIV_STAGES = QUO_W;
   localparam int STATUS_W  = 2;

   // Queue between the front and the back
   localparam int Q_DEPTH   = 32;
   localparam int Q_IDX_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = Q_IDX_W + 1;

   // CSR port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_COEF_R2 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_R4 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_R6 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_R8 = CSR_IDX_W'(3);

   localparam logic [STATUS_W-1:0] STATUS_OK   = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_SAT  = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_ZERO = STATUS_W'(2);

   localparam logic [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [ACC_W-1:0] MAG_TOP  = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [ACC_W-1:0] FIX_ONE  = ACC_W'(1) << FRAC_BITS;

   localparam logic [QUO_W-1:0] QUO_NEG_LIM = QUO_W'(1) << (XY_W-1);
   localparam logic [QUO_W-1:0] QUO_POS_LIM = QUO_NEG_LIM - QUO_W'(1);
   localparam logic [XY_W-1:0]  XY_MAX      = {1'b0, {(XY_W-1){1'b1}}};
   localparam logic [XY_W-1:0]  XY_MIN      = {1'b1, {(XY_W-1){1'b0}}};

   // Point travelling through the front pipeline
   typedef struct packed {
      logic                    valid;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic [R_W-1:0]          r;
      logic signed [ACC_W-1:0] acc;
      logic                    sat;
   } pt_type;

   // Queue entry: point plus its divisor
   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ACC_W-1:0] w;
      logic                    sat;
   } mid_type;

   // One lane of the restoring divider
   typedef struct packed {
      logic [ACC_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [QUO_W-1:0] low;
   } lane_type;

   typedef struct packed {
      logic             valid;
      lane_type         lane_x;
      lane_type         lane_y;
      logic [ACC_W-1:0] dvs;
      logic             neg_x;
      logic             neg_y;
      logic             ovf_x;
      logic             ovf_y;
      logic             zero;
      logic             sat;
   } div_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   typedef struct packed {
      logic [ACC_W-1:0] val;
      logic             sat;
   } sval_type;

   typedef struct packed {
      logic [XY_W-1:0] val;
      logic            sat;
   } qval_type;

   // Signed 64-bit add, clamped to the range
   function automatic sval_type add_sat(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
      logic [ACC_W:0] sum;
      sval_type       res;
      sum     = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      res.sat = sum[ACC_W] != sum[ACC_W-1];
      if (res.sat) begin
         res.val = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         res.val = sum[ACC_W-1:0];
      end
      return res;
   endfunction

   // One quotient bit of the restoring divider
   function automatic lane_type div_step(input lane_type s, input logic [ACC_W-1:0] dvs);
      logic [ACC_W:0] trial;
      lane_type       n;
      trial = {s.rem, s.low[QUO_W-1]};
      n.low = s.low << 1;
      if (trial >= {1'b0, dvs}) begin
         n.rem = ACC_W'(trial - {1'b0, dvs});
         n.quo = {s.quo[QUO_W-2:0], 1'b1};
      end else begin
         n.rem = trial[ACC_W-1:0];
         n.quo = {s.quo[QUO_W-2:0], 1'b0};
      end
      return n;
   endfunction

   // Signed 32-bit result from a quotient magnitude, clamped
   function automatic qval_type quo_clamp(input logic [QUO_W-1:0] q, input logic neg,
                                          input logic ovf);
      qval_type res;
      res.sat = 1'b0;
      if (neg) begin
         if (ovf || q > QUO_NEG_LIM) begin
            res.sat = 1'b1;
            res.val = XY_MIN;
         end else begin
            res.val = XY_W'(~q + QUO_W'(1));
         end
      end else begin
         if (ovf || q > QUO_POS_LIM) begin
            res.sat = 1'b1;
            res.val = XY_MAX;
         end else begin
            res.val = q[XY_W-1:0];
         end
      end
      return res;
   endfunction

endpackage

// ===== src/rup_if.sv =====
// Channel interfaces for point requests, responses and CSR writes.
`timescale 1ns / 1ps

interface rup_req_if
   import rup_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic signed [XY_W-1:0] x_in;
   logic signed [XY_W-1:0] y_in;
   modport source (output valid, x_in, y_in, input ready);
   modport sink   (input valid, x_in, y_in, output ready);
endinterface

interface rup_rsp_if
   import rup_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic signed [XY_W-1:0] x_out;
   logic signed [XY_W-1:0] y_out;
   logic [STATUS_W-1:0]    status;
   modport source (output valid, x_out, y_out, status, input ready);
   modport sink   (input valid, x_out, y_out, status, output ready);
endinterface

interface rup_csr_if
   import rup_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rup_step.sv =====
// One Horner step: acc = addend + floor(acc * r), six pipeline stages.
`timescale 1ns / 1ps

module rup_step
   import rup_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  pt_type           step_in,
   input  logic [ACC_W-1:0] addend,
   output pt_type           step_out
);

   pt_type pay1_ff, pay2_ff, pay3_ff, pay4_ff, pay5_ff, pay6_ff;
   pt_type pay5_in, pay6_in;

   logic [ACC_W-1:0]     mag1_ff, mag1_in;
   logic [63:0]          p00_ff, p00_in;
   logic [32+B1_W-1:0]   p01_ff, p01_in;
   logic [63:0]          p10_ff, p10_in;
   logic [32+B1_W-1:0]   p11_ff, p11_in;
   logic [PROD_W-1:0]    prod3_ff, prod3_in;
   logic [ACC_W:0]       qc4_ff, qc4_in;
   logic                 over4_ff, over4_in;
   logic [ACC_W-1:0]     val5_ff;
   sval_type             clamp5;
   sval_type             sum6;

   // stage 1: magnitude of acc
   assign mag1_in = step_in.acc[ACC_W-1] ? (~step_in.acc + ACC_W'(1)) : step_in.acc;

   // stage 2: four partial products, two 32x32 and two 32x8
   assign p00_in = mag1_ff[31:0] * pay1_ff.r[31:0];
   assign p01_in = mag1_ff[31:0] * pay1_ff.r[R_W-1:32];
   assign p10_in = mag1_ff[63:32] * pay1_ff.r[31:0];
   assign p11_in = mag1_ff[63:32] * pay1_ff.r[R_W-1:32];

   // stage 3: full product
   assign prod3_in = PROD_W'(p00_ff) + (PROD_W'(p01_ff) << 32) + (PROD_W'(p10_ff) << 32)
                   + (PROD_W'(p11_ff) << 64);

   // stage 4: drop fraction bits, bump magnitude for floor of negatives
   always_comb begin
      qc4_in   = {1'b0, prod3_ff[FRAC_BITS+ACC_W-1:FRAC_BITS]}
               + (ACC_W+1)'(pay3_ff.acc[ACC_W-1] & (|prod3_ff[FRAC_BITS-1:0]));
      over4_in = |prod3_ff[PROD_W-1:FRAC_BITS+ACC_W];
   end

   // stage 5: back to signed, clamped
   always_comb begin
      clamp5.sat = 1'b0;
      if (pay4_ff.acc[ACC_W-1]) begin
         if (over4_ff || qc4_ff[ACC_W] || qc4_ff[ACC_W-1:0] > MAG_TOP) begin
            clamp5.sat = 1'b1;
            clamp5.val = ACC_MIN;
         end else begin
            clamp5.val = ~qc4_ff[ACC_W-1:0] + ACC_W'(1);
         end
      end else begin
         if (over4_ff || qc4_ff[ACC_W] || qc4_ff[ACC_W-1]) begin
            clamp5.sat = 1'b1;
            clamp5.val = ACC_MAX;
         end else begin
            clamp5.val = qc4_ff[ACC_W-1:0];
         end
      end
      pay5_in     = pay4_ff;
      pay5_in.sat = pay4_ff.sat | clamp5.sat;
   end

   // stage 6: add the coefficient
   always_comb begin
      sum6        = add_sat(addend, val5_ff);
      pay6_in     = pay5_ff;
      pay6_in.acc = sum6.val;
      pay6_in.sat = pay5_ff.sat | sum6.sat;
   end

   always_ff @(posedge clock) begin
      mag1_ff  <= mag1_in;
      p00_ff   <= p00_in;
      p01_ff   <= p01_in;
      p10_ff   <= p10_in;
      p11_ff   <= p11_in;
      prod3_ff <= prod3_in;
      qc4_ff   <= qc4_in;
      over4_ff <= over4_in;
      val5_ff  <= clamp5.val;
      if (reset) begin
         pay1_ff.valid <= 1'b0;
         pay2_ff.valid <= 1'b0;
         pay3_ff.valid <= 1'b0;
         pay4_ff.valid <= 1'b0;
         pay5_ff.valid <= 1'b0;
         pay6_ff.valid <= 1'b0;
      end else begin
         pay1_ff <= step_in;
         pay2_ff <= pay1_ff;
         pay3_ff <= pay2_ff;
         pay4_ff <= pay3_ff;
         pay5_ff <= pay5_in;
         pay6_ff <= pay6_in;
      end
   end

   assign step_out = pay6_ff;

endmodule

// ===== src/rup_front.sv =====
// Front: squares the coordinates, sums them to r and runs the four Horner steps to get the divisor.
`timescale 1ns / 1ps

module rup_front
   import rup_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [XY_W-1:0] in_x,
   input  logic signed [XY_W-1:0] in_y,
   input  logic [XY_W-1:0]        coef_r2,
   input  logic [XY_W-1:0]        coef_r4,
   input  logic [XY_W-1:0]        coef_r6,
   input  logic [XY_W-1:0]        coef_r8,
   output logic                   out_valid,
   output mid_type                out_data
);

   logic                   v1_ff, v2_ff;
   logic signed [XY_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [2*XY_W-1:0]      sqx2_ff, sqx2_in, sqy2_ff, sqy2_in;
   logic [XY_W-1:0]        mx, my;
   logic [2*XY_W:0]        rsum;
   pt_type                 head_ff, head_in;
   pt_type                 chain [0:4];
   logic [ACC_W-1:0]       addend [0:3];

   // squares of the coordinate magnitudes
   always_comb begin
      mx      = x1_ff[XY_W-1] ? (~x1_ff + XY_W'(1)) : x1_ff;
      my      = y1_ff[XY_W-1] ? (~y1_ff + XY_W'(1)) : y1_ff;
      sqx2_in = mx * mx;
      sqy2_in = my * my;
   end

   // r and the Horner seed
   always_comb begin
      rsum          = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
      head_in.valid = v2_ff;
      head_in.x     = x2_ff;
      head_in.y     = y2_ff;
      head_in.r     = rsum[FRAC_BITS+R_W-1:FRAC_BITS];
      head_in.acc   = {{(ACC_W-XY_W){coef_r8[XY_W-1]}}, coef_r8};
      head_in.sat   = 1'b0;
   end

   always_ff @(posedge clock) begin
      x1_ff   <= in_x;
      y1_ff   <= in_y;
      x2_ff   <= x1_ff;
      y2_ff   <= y1_ff;
      sqx2_ff <= sqx2_in;
      sqy2_ff <= sqy2_in;
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         head_ff.valid <= 1'b0;
      end else begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         head_ff <= head_in;
      end
   end

   assign addend[0] = {{(ACC_W-XY_W){coef_r6[XY_W-1]}}, coef_r6};
   assign addend[1] = {{(ACC_W-XY_W){coef_r4[XY_W-1]}}, coef_r4};
   assign addend[2] = {{(ACC_W-XY_W){coef_r2[XY_W-1]}}, coef_r2};
   assign addend[3] = FIX_ONE;
   assign chain[0]  = head_ff;

   // Horner chain, highest coefficient first
   for (genvar k = 0; k < 4; k++) begin : g_step
      rup_step u_step (
         .clock    (clock),
         .reset    (reset),
         .step_in  (chain[k]),
         .addend   (addend[k]),
         .step_out (chain[k+1])
      );
   end

   assign out_valid    = chain[4].valid;
   assign out_data.x   = chain[4].x;
   assign out_data.y   = chain[4].y;
   assign out_data.w   = chain[4].acc;
   assign out_data.sat = chain[4].sat;

endmodule

// ===== src/rup_queue.sv =====
// Small FIFO between front and back.
`timescale 1ns / 1ps

module rup_queue
   import rup_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  mid_type   push_data,
   input  logic      pop,
   output mid_type   pop_data,
   output qstat_type qstat
);

   mid_type            mem_ff [0:Q_DEPTH-1];
   logic [Q_IDX_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_IDX_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_IDX_W'(1) : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign pop_data    = mem_ff[rd_ptr_ff];
   assign qstat.empty = count_ff == '0;
   assign qstat.full  = count_ff == Q_CNT_W'(Q_DEPTH);

endmodule

// ===== src/rup_back.sv =====
// Back: two-lane restoring divider, one quotient bit per stage, and the output register.
`timescale 1ns / 1ps

module rup_back
   import rup_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  qstat_type              qstat,
   input  mid_type                pop_data,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [XY_W-1:0] out_x,
   output logic signed [XY_W-1:0] out_y,
   output logic [STATUS_W-1:0]    out_status
);

   div_type               stg_ff [0:DIV_STAGES];
   div_type               stg_in [0:DIV_STAGES];
   div_type               prep;
   logic                  back_en;
   logic [XY_W-1:0]       mag_x, mag_y;
   logic [NUM_W-1:0]      num_x, num_y;
   logic [ACC_W-1:0]      hi_x, hi_y;
   qval_type              res_x, res_y;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [XY_W-1:0]       x_ff, x_in, y_ff, y_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   // the whole back advances unless a response is held
   assign back_en = !rsp_valid_ff || out_ready;
   assign pop     = back_en && !qstat.empty;

   // operand setup: numerator split into top part and bits fed per stage
   always_comb begin
      mag_x = pop_data.x[XY_W-1] ? (~pop_data.x + XY_W'(1)) : pop_data.x;
      mag_y = pop_data.y[XY_W-1] ? (~pop_data.y + XY_W'(1)) : pop_data.y;
      num_x = {mag_x, {FRAC_BITS{1'b0}}};
      num_y = {mag_y, {FRAC_BITS{1'b0}}};
      hi_x  = ACC_W'(num_x[NUM_W-1:QUO_W]);
      hi_y  = ACC_W'(num_y[NUM_W-1:QUO_W]);
      prep.valid      = pop;
      prep.dvs        = pop_data.w[ACC_W-1] ? (~pop_data.w + ACC_W'(1)) : pop_data.w;
      prep.lane_x.rem = hi_x;
      prep.lane_x.quo = '0;
      prep.lane_x.low = num_x[QUO_W-1:0];
      prep.lane_y.rem = hi_y;
      prep.lane_y.quo = '0;
      prep.lane_y.low = num_y[QUO_W-1:0];
      prep.neg_x      = pop_data.x[XY_W-1] ^ pop_data.w[ACC_W-1];
      prep.neg_y      = pop_data.y[XY_W-1] ^ pop_data.w[ACC_W-1];
      prep.ovf_x      = hi_x >= prep.dvs;
      prep.ovf_y      = hi_y >= prep.dvs;
      prep.zero       = pop_data.w == '0;
      prep.sat        = pop_data.sat;
   end

   // divider stages
   always_comb begin
      stg_in[0] = prep;
      for (int i = 0; i < DIV_STAGES; i++) begin
         stg_in[i+1]        = stg_ff[i];
         stg_in[i+1].lane_x = div_step(stg_ff[i].lane_x, stg_ff[i].dvs);
         stg_in[i+1].lane_y = div_step(stg_ff[i].lane_y, stg_ff[i].dvs);
      end
   end

   // clamp and status
   always_comb begin
      res_x        = quo_clamp(stg_ff[DIV_STAGES].lane_x.quo, stg_ff[DIV_STAGES].neg_x,
                               stg_ff[DIV_STAGES].ovf_x);
      res_y        = quo_clamp(stg_ff[DIV_STAGES].lane_y.quo, stg_ff[DIV_STAGES].neg_y,
                               stg_ff[DIV_STAGES].ovf_y);
      rsp_valid_in = stg_ff[DIV_STAGES].valid;
      if (stg_ff[DIV_STAGES].zero) begin
         x_in      = '0;
         y_in      = '0;
         status_in = STATUS_ZERO;
      end else begin
         x_in      = res_x.val;
         y_in      = res_y.val;
         status_in = (stg_ff[DIV_STAGES].sat || res_x.sat || res_y.sat) ? STATUS_SAT
                                                                          : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STAGES; i++) begin
            stg_ff[i].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         for (int i = 0; i <= DIV_STAGES; i++) begin
            stg_ff[i] <= stg_in[i];
         end
         x_ff         <= x_in;
         y_ff         <= y_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_status = status_ff;

endmodule

// ===== src/radial_undistort_point_top.sv =====
// Top level of the radial undistortion block: CSRs, front, queue, back.
`timescale 1ns / 1ps

// Undistorts one point (x, y) per beat by the four-coefficient division model,
// x/w and y/w with w = 1 + c2*r + c4*r^2 + c6*r^3 + c8*r^4, r = x^2 + y^2, all in
// signed Q.24. The block accepts one point every cycle and gives one response per
// point in order. The front is the input register, squares and seed, then four
// Horner steps of six stages, each built around two 32x32 and two 32x8 multipliers;
// the back is the queue write, setup, a 33-stage restoring divider that retires one
// quotient bit per stage in each of two lanes, and the output register. A 32-entry
// queue decouples the two parts; the input stalls only once 32 points sit between
// the input and the divider. Coefficients are written by index 0..3 (c2, c4, c6, c8);
// the user must write them only while the block is idle, as the block itself does not
// enforce this; other indexes are ignored.
// Status is 0 for ok, 1 when a clamp occurred, 2 when w was zero (result 0, 0).
module radial_undistort_point_top
   import rup_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   rup_req_if.sink   req_bus,
   rup_rsp_if.source rsp_bus,
   rup_csr_if.sink   csr_bus
);

   logic [XY_W-1:0]    coef_r2_ff, coef_r4_ff, coef_r6_ff, coef_r8_ff;
   logic [Q_CNT_W-1:0] credit_ff, credit_in;
   logic               accept;
   logic               front_valid;
   mid_type            front_data;
   mid_type            pop_data;
   logic               pop;
   qstat_type          qstat;

   // CSR writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_r2_ff <= '0;
         coef_r4_ff <= '0;
         coef_r6_ff <= '0;
         coef_r8_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_COEF_R2: coef_r2_ff <= csr_bus.data;
            REG_COEF_R4: coef_r4_ff <= csr_bus.data;
            REG_COEF_R6: coef_r6_ff <= csr_bus.data;
            REG_COEF_R8: coef_r8_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // credits cover points in the front pipeline plus the queue
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = credit_ff < Q_CNT_W'(Q_DEPTH);
   assign credit_in     = credit_ff + Q_CNT_W'(accept) - Q_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   rup_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_x      (req_bus.x_in),
      .in_y      (req_bus.y_in),
      .coef_r2   (coef_r2_ff),
      .coef_r4   (coef_r4_ff),
      .coef_r6   (coef_r6_ff),
      .coef_r8   (coef_r8_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   rup_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   rup_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .pop_data   (pop_data),
      .pop        (pop),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_x      (rsp_bus.x_out),
      .out_y      (rsp_bus.y_out),
      .out_status (rsp_bus.status)
   );

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("credit count above queue depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      front_valid |-> !qstat.full || pop)
      else $error("front pushed into a full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == STATUS_ZERO |->
         rsp_bus.x_out == '0 && rsp_bus.y_out == '0)
      else $error("zero divisor response carries nonzero point");
`endif

endmodule

// ===== tb/tb_if.sv =====
// Idle profile constants for the bench.
`timescale 1ns / 1ps

package tb_idle_pkg;
   // Idle profiles: percent chance of a gap or stall each cycle
   localparam int IDLE_NONE = 0;
   localparam int IDLE_HALF = 52;
   localparam int IDLE_BOTH = 11;
endpackage

// ===== tb/tb_top.sv =====
// Self-checking bench for the radial undistortion block: predicts each point in Q.24.
`timescale 1ns / 1ps

module tb_top;
   import rup_pkg::*;
   import tb_idle_pkg::*;

   logic clock;
   logic reset;
   rup_req_if req_bus ();
   rup_rsp_if rsp_bus ();
   rup_csr_if csr_bus ();

   radial_undistort_point_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   typedef struct {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic [STATUS_W-1:0]    st;
   } point_type;

   // Coefficient shadow copy, c2..c8
   logic signed [63:0] coef [4];
   point_type          pending_pts[$];
   int                 error_count;
   int                 send_gap_pct;
   int                 stall_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // floor(a*r / 2^FRAC) with clamp to int64
   function automatic logic signed [63:0] mul_floor(input logic signed [63:0] a,
                                                    input logic [63:0] r,
                                                    inout logic sat);
      logic signed [159:0] p;
      p = (160'(signed'(a)) * signed'({96'd0, r})) >>> FRAC_BITS;
      if (p > 160'sh7FFFFFFFFFFFFFFF) begin
         sat = 1'b1;
         return 64'sh7FFFFFFFFFFFFFFF;
      end
      if (p < -160'sh8000000000000000) begin
         sat = 1'b1;
         return 64'sh8000000000000000;
      end
      return p[63:0];
   endfunction

   function automatic logic signed [63:0] sum_clamp(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    inout logic sat);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         sat = 1'b1;
         return s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
      end
      return s[63:0];
   endfunction

   // trunc(v*2^FRAC / w) clamped to 32 bits
   function automatic logic signed [31:0] quotient(input logic signed [31:0] v,
                                                   input logic signed [63:0] w,
                                                   inout logic sat);
      logic signed [127:0] q;
      q = (128'(v) <<< FRAC_BITS) / 128'(w);
      if (q > 128'sh7FFFFFFF) begin
         sat = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (q < -128'sh80000000) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return q[31:0];
   endfunction

   function automatic point_type undistort(input logic signed [31:0] x,
                                           input logic signed [31:0] y);
      logic [63:0]        rad;
      logic signed [63:0] acc;
      logic signed [63:0] prod;
      logic               sat;
      point_type          res;
      rad = (64'(x * 64'sd1) * 64'(x * 64'sd1) + 64'(y * 64'sd1) * 64'(y * 64'sd1))
            >> FRAC_BITS;
      sat  = 1'b0;
      acc  = coef[3];
      prod = mul_floor(acc, rad, sat);
      acc  = sum_clamp(coef[2], prod, sat);
      prod = mul_floor(acc, rad, sat);
      acc  = sum_clamp(coef[1], prod, sat);
      prod = mul_floor(acc, rad, sat);
      acc  = sum_clamp(coef[0], prod, sat);
      prod = mul_floor(acc, rad, sat);
      acc  = sum_clamp(64'sd1 <<< FRAC_BITS, prod, sat);
      if (acc == 0) begin
         res.x  = '0;
         res.y  = '0;
         res.st = STATUS_ZERO;
      end else begin
         res.x  = quotient(x, acc, sat);
         res.y  = quotient(y, acc, sat);
         res.st = sat ? STATUS_SAT : STATUS_OK;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Response checker and receiver stall generator
   initial begin
      point_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_pts.size() == 0) begin
               report_mismatch("unexpected beat", rsp_bus.x_out, 0);
            end else begin
               want = pending_pts.pop_front();
               if (rsp_bus.x_out !== want.x) report_mismatch("x_out", rsp_bus.x_out, want.x);
               if (rsp_bus.y_out !== want.y) report_mismatch("y_out", rsp_bus.y_out, want.y);
               if (rsp_bus.status !== want.st)
                  report_mismatch("status", 32'(rsp_bus.status), 32'(want.st));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // valid stays high between back-to-back beats; gaps and drains drop it
   task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.x_in  <= x;
      req_bus.y_in  <= y;
      do @(posedge clock); while (!req_bus.ready);
      pending_pts.push_back(undistort(x, y));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_pts.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx <= REG_COEF_R8) coef[idx[1:0]] = signed'(val);
      @(posedge clock);
   endtask

   task automatic set_coefs(input logic [31:0] c2, input logic [31:0] c4,
                            input logic [31:0] c6, input logic [31:0] c8);
      wait_drained();
      write_coef(REG_COEF_R2, c2);
      write_coef(REG_COEF_R4, c4);
      write_coef(REG_COEF_R6, c6);
      write_coef(REG_COEF_R8, c8);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 ** 26)) - (2 ** 25));
         2: return 32'($signed($urandom_range(2 ** 22)) - (2 ** 21));
         default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 ** 24)) - (2 ** 23));
         2: return 32'($signed($urandom_range(2 ** 20)) - (2 ** 19));
         default: return '0;
      endcase
   endfunction

   // Extreme coordinates, a zero divisor, clamps and an ignored index
   task automatic test_directed();
      send_point(0, 0);
      send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_point(32'sh80000000, 32'sh80000000);
      send_point(32'sh80000000, 32'sh7FFFFFFF);
      send_point(32'sh01000000, -32'sh01000000);
      set_coefs(32'hFF000000, 0, 0, 0);        // w = 1 - r: zero at r = 1
      send_point(32'sh01000000, 0);
      send_point(0, -32'sh01000000);
      send_point(32'sh00800000, 32'sh00800000);
      send_point(32'sh7FFFFFFF, 0);
      send_point(32'sh00100000, 32'sh00200000);
      set_coefs(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_point(32'sh7FFFFFFF, 32'sh80000000);
      send_point(32'sh00000001, 32'shFFFFFFFF);
      send_point(32'sh04000000, 32'sh00000000);
      set_coefs(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_point(32'sh02000000, 32'sh00000000);
      send_point(32'sh00400000, 32'shFFC00000);
      wait_drained();
      write_coef(8'd4, 32'h12345678);
      write_coef(8'hFF, 32'hFFFFFFFF);
      send_point(32'sh00400000, 32'sh00400000);
   endtask

   task automatic test_random(input int count);
      repeat (count) begin
         send_point(rand_coord(), rand_coord());
      end
   endtask

   task automatic test_profiles();
      int gaps  [4] = '{IDLE_NONE, IDLE_HALF, IDLE_NONE, IDLE_BOTH};
      int stalls[4] = '{IDLE_NONE, IDLE_NONE, IDLE_HALF, IDLE_BOTH};
      for (int ph = 0; ph < 8; ph++) begin
         set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
         send_gap_pct = gaps[ph % 4];
         stall_pct    = stalls[ph % 4];
         test_random(195);
      end
   endtask

   initial begin
      error_count   = 0;
      send_gap_pct  = IDLE_NONE;
      stall_pct     = IDLE_NONE;
      for (int i = 0; i < 4; i++) coef[i] = '0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.x_in  <= '0;
      req_bus.y_in  <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_profiles();
      wait_drained();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Run limit
   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
